// File: sv/fdpc_pkg.sv
// Shared constants, types and helper functions of the flip-dot dirty pixel controller.
package fdpc_pkg;

  // Display geometry.
  localparam int MODULE_COLS = 28;
  localparam int MODULE_ROWS = 16;
  localparam int MAX_MODULES = 8;

  // Store layout derived from the geometry.
  localparam int COL_BYTES   = (MODULE_ROWS + 7) / 8;
  localparam int MOD_BYTES   = MODULE_COLS * COL_BYTES;
  localparam int STORE_DEPTH = MAX_MODULES * MOD_BYTES;

  // Widths of internal counters and addresses.
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int LEN_W   = $clog2(STORE_DEPTH + 1);
  localparam int MODS_W  = $clog2(MAX_MODULES + 1);
  localparam int WIDTH_W = $clog2(MAX_MODULES * MODULE_COLS + 1);
  localparam int COL_W   = $clog2(MODULE_COLS);
  localparam int CB_W    = (COL_BYTES > 1) ? $clog2(COL_BYTES) : 1;

  // Driver byte constants.
  localparam int GROUP_SIZE = 7;
  localparam int HALF_ROWS  = 14;
  localparam logic [7:0] SHOWN_RESET = 8'hff;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW_WR,
    ST_SCAN_CMP
  } fdpc_state_t;

  // One scanned byte handed to the flip sequencer.
  typedef struct packed {
    logic [7:0]         cur;
    logic [7:0]         diff;
    logic [WIDTH_W-1:0] px;
    logic [1:0]         cdiv;
    logic [2:0]         xm7;
    logic [4:0]         ybase;
    logic               fend;
  } fdpc_scan_t;

  // Module count clamped to the supported range.
  function automatic logic [MODS_W-1:0] sat_modules(input logic [3:0] n);
    logic [MODS_W-1:0] m;
    if (n == 4'd0) begin
      m = MODS_W'(1);
    end else if (n > MAX_MODULES) begin
      m = MODS_W'(MAX_MODULES);
    end else begin
      m = MODS_W'(n);
    end
    return m;
  endfunction

  // Module index of a column, by independent threshold compares.
  function automatic logic [MODS_W-1:0] col_module(input logic [7:0] x);
    logic [MODS_W-1:0] q;
    q = '0;
    for (int k = 1; k <= MAX_MODULES; k++) begin
      if (int'(x) >= k * MODULE_COLS) begin
        q = q + MODS_W'(1);
      end
    end
    return q;
  endfunction

  // Driver group of a module-local column.
  function automatic logic [1:0] col_group(input logic [COL_W-1:0] lc);
    logic [1:0] q;
    q = 2'd0;
    if (int'(lc) >= GROUP_SIZE) q = 2'd1;
    if (int'(lc) >= 2 * GROUP_SIZE) q = 2'd2;
    if (int'(lc) >= 3 * GROUP_SIZE) q = 2'd3;
    return q;
  endfunction

endpackage

// File: sv/fdpc_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module fdpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 448,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: sv/fdpc_flip_seq.sv
// Flip sequencer: walks the changed bits of one byte and drives the result register.
module fdpc_flip_seq import fdpc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  fdpc_scan_t scan,
  output logic       busy,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] col_byte,
  output logic [7:0] row_byte,
  output logic [7:0] pixel_x,
  output logic [4:0] pixel_y,
  output logic       dot_on,
  output logic       last_of_byte,
  output logic       frame_end
);

  logic [7:0]         pend;
  logic [7:0]         pend_next;
  fdpc_scan_t         sc;
  logic               fire;
  logic [2:0]         idx;
  logic [4:0]         y_full;
  logic [4:0]         yl;
  logic               rb;
  logic [2:0]         ra;
  logic [2:0]         ca;
  logic               on;
  logic [7:0]         col_calc;
  logic [7:0]         row_calc;

  assign busy = (pend != 8'd0);

  // Pick the lowest pending bit and encode its driver bytes.
  always_comb begin
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (pend[i]) begin
        idx = 3'(i);
      end
    end
    fire      = busy && (!out_valid || !out_stall);
    pend_next = pend & ~(8'd1 << idx);
    y_full    = sc.ybase + 5'(idx);
    yl        = (int'(y_full) >= HALF_ROWS) ? 5'(y_full - 5'(HALF_ROWS)) : y_full;
    rb        = (int'(yl) >= GROUP_SIZE);
    ra        = rb ? 3'(yl - 5'(GROUP_SIZE) + 5'd1) : 3'(yl + 5'd1);
    ca        = sc.xm7 + 3'd1;
    on        = sc.cur[idx];
    col_calc  = {ra[2], ~on, ca[0], ca[1], ca[2], sc.cdiv[0], sc.cdiv[1], 1'b0};
    row_calc  = {(int'(y_full) >= HALF_ROWS), on, (int'(y_full) < HALF_ROWS), on, ~on,
                 rb, ra[0], ra[1]};
  end

  // Pending bits and the scanned byte context.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 8'd0;
    end else if (load) begin
      pend <= scan.diff;
    end else if (fire) begin
      pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sc <= scan;
    end
  end

  // Result register: loads on each flip, empties when the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      col_byte     <= col_calc;
      row_byte     <= row_calc;
      pixel_x      <= sc.px[7:0];
      pixel_y      <= y_full;
      dot_on       <= on;
      last_of_byte <= (pend_next == 8'd0);
      frame_end    <= sc.fend;
    end
  end

endmodule

// File: sv/flipdot_dirty_pixel_controller.sv
// Top level of the flip-dot dirty pixel controller: control, scan counters and stores.
//
//   channel   signals                                   direction
//   input     in_valid, in_stall, func, x, y, color      in (in_stall out)
//   result    out_valid, out_stall, col_byte, row_byte,  out (out_stall in)
//             pixel_x, pixel_y, dot_on, last_of_byte,
//             frame_end
//   config    cfg_we, cfg_wdata                          in
//
// A draw reads the frame store, then writes the changed byte back.
// A scan tick reads both stores and writes the shown copy, then the flip sequencer
// issues one changed bit per cycle while out_stall does not hold it back.
// After reset a clearing pass writes all 448 entries of both stores; in_stall is high meanwhile.
// in_stall stays high while an item is at work; out_stall only holds back the sequencer.
module flipdot_dirty_pixel_controller import fdpc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       func,
  input  logic [7:0] x,
  input  logic [4:0] y,
  input  logic       color,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] col_byte,
  output logic [7:0] row_byte,
  output logic [7:0] pixel_x,
  output logic [4:0] pixel_y,
  output logic       dot_on,
  output logic       last_of_byte,
  output logic       frame_end,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata
);

  fdpc_state_t        state;
  fdpc_state_t        state_next;
  logic [3:0]         num_modules;
  logic [ADDR_W-1:0]  clr_addr;

  // Scan position counters.
  logic [ADDR_W-1:0]  ptr;
  logic [COL_W-1:0]   lcol;
  logic [WIDTH_W-1:0] px;
  logic [2:0]         xm7;
  logic [CB_W-1:0]    cb;

  // Latched item.
  logic [ADDR_W-1:0]  d_addr;
  logic [2:0]         d_bit;
  logic               d_color;
  logic [ADDR_W-1:0]  s_addr;
  logic [COL_W-1:0]   s_lcol;
  logic [WIDTH_W-1:0] s_px;
  logic [2:0]         s_xm7;
  logic [CB_W-1:0]    s_cb;
  logic               s_fend;

  // Combinational item decode.
  logic [MODS_W-1:0]  mods;
  logic [LEN_W-1:0]   frame_len;
  logic [WIDTH_W-1:0] frame_cols;
  logic               accept;
  logic               draw_ok;
  logic [MODS_W-1:0]  x_mod;
  logic [COL_W-1:0]   x_col;
  logic [ADDR_W-1:0]  draw_addr;
  logic               wrap;
  logic [ADDR_W-1:0]  e_ptr;
  logic [COL_W-1:0]   e_lcol;
  logic [WIDTH_W-1:0] e_px;
  logic [2:0]         e_xm7;
  logic [CB_W-1:0]    e_cb;
  logic               e_fend;
  logic               cb_last;
  logic               col_last;

  // Store ports.
  logic               frame_we;
  logic [ADDR_W-1:0]  frame_waddr;
  logic [7:0]         frame_wdata;
  logic               shown_we;
  logic [ADDR_W-1:0]  shown_waddr;
  logic [7:0]         shown_wdata;
  logic [ADDR_W-1:0]  rd_addr;
  logic [7:0]         frame_rdata;
  logic [7:0]         shown_rdata;
  logic [7:0]         draw_mask;
  logic [7:0]         pad_mask;
  logic [4:0]         s_ybase;

  logic               seq_load;
  logic               seq_busy;
  fdpc_scan_t         seq_scan;

  // Geometry from the module count register.
  always_comb begin
    mods       = sat_modules(num_modules);
    frame_len  = LEN_W'(int'(mods) * MOD_BYTES);
    frame_cols = WIDTH_W'(int'(mods) * MODULE_COLS);
  end

  // Draw address decode.
  always_comb begin
    draw_ok   = (x < frame_cols) && (int'(y) < MODULE_ROWS);
    x_mod     = col_module(x);
    x_col     = COL_W'(int'(x) - int'(x_mod) * MODULE_COLS);
    draw_addr = ADDR_W'(int'(x_mod) * MOD_BYTES + int'(x_col) * COL_BYTES + int'(y >> 3));
  end

  // Effective scan position, wrapped when the frame shrank.
  always_comb begin
    wrap = (LEN_W'(ptr) >= frame_len);
    if (wrap) begin
      e_ptr  = '0;
      e_lcol = '0;
      e_px   = '0;
      e_xm7  = 3'd0;
      e_cb   = '0;
    end else begin
      e_ptr  = ptr;
      e_lcol = lcol;
      e_px   = px;
      e_xm7  = xm7;
      e_cb   = cb;
    end
    e_fend   = (LEN_W'(e_ptr) == frame_len - LEN_W'(1));
    cb_last  = (int'(e_cb) == COL_BYTES - 1);
    col_last = (int'(e_lcol) == MODULE_COLS - 1);
  end

  // Handshake and read address.
  assign in_stall = (state != ST_IDLE) || seq_busy;
  assign accept   = in_valid && !in_stall;
  assign rd_addr  = func ? e_ptr : draw_addr;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (int'(clr_addr) == STORE_DEPTH - 1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (func) begin
            state_next = ST_SCAN_CMP;
          end else if (draw_ok) begin
            state_next = ST_DRAW_WR;
          end
        end
      end
      ST_DRAW_WR:  state_next = ST_IDLE;
      ST_SCAN_CMP: state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Store write controls and sequencer load.
  always_comb begin
    draw_mask = 8'd1 << d_bit;
    s_ybase   = 5'({s_cb, 3'b000});
    for (int b = 0; b < 8; b++) begin
      pad_mask[b] = (int'(s_ybase) + b < MODULE_ROWS);
    end
    frame_we    = 1'b0;
    frame_waddr = d_addr;
    frame_wdata = d_color ? (frame_rdata | draw_mask) : (frame_rdata & ~draw_mask);
    shown_we    = 1'b0;
    shown_waddr = s_addr;
    shown_wdata = frame_rdata;
    seq_load    = 1'b0;
    case (state)
      ST_CLEAR: begin
        frame_we    = 1'b1;
        frame_waddr = clr_addr;
        frame_wdata = 8'd0;
        shown_we    = 1'b1;
        shown_waddr = clr_addr;
        shown_wdata = SHOWN_RESET;
      end
      ST_DRAW_WR: begin
        frame_we = 1'b1;
      end
      ST_SCAN_CMP: begin
        shown_we = 1'b1;
        seq_load = 1'b1;
      end
      default: begin
      end
    endcase
    seq_scan.cur   = frame_rdata;
    seq_scan.diff  = (frame_rdata ^ shown_rdata) & pad_mask;
    seq_scan.px    = s_px;
    seq_scan.cdiv  = col_group(s_lcol);
    seq_scan.xm7   = s_xm7;
    seq_scan.ybase = s_ybase;
    seq_scan.fend  = s_fend;
  end

  // State and clearing pass counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

  // Module count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_modules <= 4'd1;
    end else if (cfg_we) begin
      num_modules <= cfg_wdata;
    end
  end

  // Scan pointer and its position counters advance on each accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      lcol <= '0;
      px   <= '0;
      xm7  <= 3'd0;
      cb   <= '0;
    end else if (accept && func) begin
      if (e_fend) begin
        ptr  <= '0;
        lcol <= '0;
        px   <= '0;
        xm7  <= 3'd0;
        cb   <= '0;
      end else begin
        ptr <= e_ptr + ADDR_W'(1);
        if (cb_last) begin
          cb   <= '0;
          lcol <= col_last ? '0 : e_lcol + COL_W'(1);
          px   <= e_px + WIDTH_W'(1);
          xm7  <= (int'(e_xm7) == GROUP_SIZE - 1) ? 3'd0 : e_xm7 + 3'd1;
        end else begin
          cb <= e_cb + CB_W'(1);
          lcol <= e_lcol;
          px   <= e_px;
          xm7  <= e_xm7;
        end
      end
    end
  end

  // Item fields held for the write-back cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      d_addr  <= draw_addr;
      d_bit   <= y[2:0];
      d_color <= color;
      s_addr  <= e_ptr;
      s_lcol  <= e_lcol;
      s_px    <= e_px;
      s_xm7   <= e_xm7;
      s_cb    <= e_cb;
      s_fend  <= e_fend;
    end
  end

  // Frame store and shown store.
  fdpc_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_frame_ram (
    .clk   (clk),
    .we    (frame_we),
    .waddr (frame_waddr),
    .wdata (frame_wdata),
    .raddr (rd_addr),
    .rdata (frame_rdata)
  );

  fdpc_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_shown_ram (
    .clk   (clk),
    .we    (shown_we),
    .waddr (shown_waddr),
    .wdata (shown_wdata),
    .raddr (rd_addr),
    .rdata (shown_rdata)
  );

  // Flip sequencer and result register.
  fdpc_flip_seq u_flip_seq (
    .clk          (clk),
    .rst          (rst),
    .load         (seq_load),
    .scan         (seq_scan),
    .busy         (seq_busy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .col_byte     (col_byte),
    .row_byte     (row_byte),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .dot_on       (dot_on),
    .last_of_byte (last_of_byte),
    .frame_end    (frame_end)
  );

endmodule
